/* hdl/kcl_pkg.sv */
package kcl_pkg;

  localparam int CODE_LEN_DEF = 4;
  localparam int DIGIT_W = 3;
  localparam int REG_W = 16;
  localparam int MASTER_DIGITS = 4;
  localparam int NIBBLE_W = 4;

  localparam logic [2:0] CMD_TICK = 3'd0;
  localparam logic [2:0] CMD_DIGIT = 3'd1;
  localparam logic [2:0] CMD_MOVE = 3'd2;
  localparam logic [2:0] CMD_CONFIRM = 3'd3;
  localparam logic [2:0] CMD_CHANGE = 3'd4;

  localparam logic [2:0] KEY_MIN = 3'd1;
  localparam logic [2:0] KEY_MAX = 3'd4;

  localparam logic [2:0] OUT_MATCH = 3'd0;
  localparam logic [2:0] OUT_MASTER = 3'd1;
  localparam logic [2:0] OUT_MISMATCH = 3'd2;
  localparam logic [2:0] OUT_SAVED = 3'd3;
  localparam logic [2:0] OUT_REJECTED = 3'd4;

  localparam logic [1:0] MODE_UNLOCK = 2'd0;
  localparam logic [1:0] MODE_FIRST = 2'd1;
  localparam logic [1:0] MODE_SECOND = 2'd2;

  localparam logic [1:0] REG_MASTER = 2'd0;
  localparam logic [1:0] REG_ENTRY_TO = 2'd1;
  localparam logic [1:0] REG_EDIT_TO = 2'd2;

  localparam logic [REG_W-1:0] MASTER_RESET = 16'h1144;
  localparam logic [REG_W-1:0] TIMEOUT_RESET = 16'hFFFF;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [REG_W-1:0] reg_t;

  function automatic reg_t load_of(input reg_t value);
    return (value == '0) ? reg_t'(1) : value;
  endfunction

endpackage

/* hdl/keypad_code_lock_entry.sv */
// Channel  | Signals                      | Direction
// request  | in_valid, in_stall, cmd,     | into the block
//          | key_digit                    |
// result   | out_valid, out_stall,        | out of the block
//          | outcome, digits_entered      |
// config   | cfg_we, cfg_index, cfg_data  | into the block
// Each request is handled in the cycle it is accepted; its result is registered.
// A new request can be accepted every cycle; the limit is the two-entry result buffer.
// in_stall rises only when both result slots are full; it ignores out_stall.
// Synchronous reset on rst clears entry state and stored code; config gets defaults.
module keypad_code_lock_entry import kcl_pkg::*; #(
  parameter int CODE_LEN = CODE_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           cmd,
  input  logic [2:0]           key_digit,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           outcome,
  output logic [2:0]           digits_entered,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  localparam int CW = $clog2(CODE_LEN + 1);
  localparam int PW = $clog2(CODE_LEN);

  reg_t master_code, entry_timeout, edit_timeout;

  logic [1:0]    entry_mode, entry_mode_next;
  logic          editing, editing_next;
  digit_t        entry_digits [CODE_LEN];
  digit_t        entry_digits_next [CODE_LEN];
  digit_t        stored_code [CODE_LEN];
  digit_t        stored_code_next [CODE_LEN];
  digit_t        first_entry [CODE_LEN];
  digit_t        first_entry_next [CODE_LEN];
  logic [CW-1:0] write_count, write_count_next;
  logic [PW-1:0] cursor, cursor_next;
  reg_t          entry_timer, entry_timer_next;
  reg_t          edit_timer, edit_timer_next;

  logic [NIBBLE_W-1:0] master_dig [CODE_LEN];

  logic          accept;
  logic          finish;
  logic [CW-1:0] fin_count;
  logic [CW-1:0] wc_inc;
  logic          same_stored, same_master, same_first;
  logic          res_valid;
  logic [2:0]    res_outcome;
  logic [2:0]    res_count;

  logic          skid_valid;
  logic [2:0]    skid_outcome, skid_count;
  logic          pop;

  assign accept = in_valid && !in_stall;
  assign in_stall = skid_valid;
  assign pop = out_valid && !out_stall;

  for (genvar g = 0; g < CODE_LEN; g++) begin : g_master
    if (g < MASTER_DIGITS) begin : g_nib
      assign master_dig[g] = master_code[(MASTER_DIGITS-1-g)*NIBBLE_W +: NIBBLE_W];
    end else begin : g_zero
      assign master_dig[g] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      master_code <= MASTER_RESET;
      entry_timeout <= TIMEOUT_RESET;
      edit_timeout <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MASTER: master_code <= cfg_data;
        REG_ENTRY_TO: entry_timeout <= cfg_data;
        REG_EDIT_TO: edit_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    entry_mode_next = entry_mode;
    editing_next = editing;
    write_count_next = write_count;
    cursor_next = cursor;
    entry_timer_next = entry_timer;
    edit_timer_next = edit_timer;
    entry_digits_next = entry_digits;
    stored_code_next = stored_code;
    first_entry_next = first_entry;
    finish = 1'b0;
    fin_count = write_count;
    wc_inc = write_count + CW'(1);
    res_valid = 1'b0;
    res_outcome = OUT_MATCH;
    same_stored = 1'b1;
    same_master = 1'b1;
    same_first = 1'b1;

    case (cmd)
      CMD_TICK: begin
        if (editing) begin
          if (edit_timer <= reg_t'(1)) begin
            editing_next = 1'b0;
          end else begin
            edit_timer_next = edit_timer - reg_t'(1);
          end
        end else if (entry_timer <= reg_t'(1)) begin
          finish = 1'b1;
        end else begin
          entry_timer_next = entry_timer - reg_t'(1);
        end
      end
      CMD_DIGIT: begin
        if (key_digit inside {[KEY_MIN:KEY_MAX]}) begin
          if (editing) begin
            if (CW'(cursor) < write_count) begin
              for (int i = 0; i < CODE_LEN; i++) begin
                if (PW'(i) == cursor) entry_digits_next[i] = key_digit;
              end
              edit_timer_next = load_of(edit_timeout);
            end
          end else begin
            for (int i = 0; i < CODE_LEN; i++) begin
              if (CW'(i) == write_count) entry_digits_next[i] = key_digit;
            end
            write_count_next = wc_inc;
            entry_timer_next = load_of(entry_timeout);
            if (wc_inc == CW'(CODE_LEN)) begin
              finish = 1'b1;
              fin_count = wc_inc;
            end else begin
              cursor_next = wc_inc[PW-1:0];
            end
          end
        end
      end
      CMD_MOVE: begin
        cursor_next = (cursor == PW'(CODE_LEN - 1)) ? '0 : cursor + PW'(1);
        editing_next = 1'b1;
        edit_timer_next = load_of(edit_timeout);
      end
      CMD_CONFIRM: begin
        if (editing) begin
          editing_next = 1'b0;
          cursor_next = write_count[PW-1:0];
        end else begin
          finish = 1'b1;
        end
      end
      CMD_CHANGE: begin
        entry_mode_next = MODE_FIRST;
        for (int i = 0; i < CODE_LEN; i++) begin
          first_entry_next[i] = '0;
          entry_digits_next[i] = '0;
        end
        write_count_next = '0;
        cursor_next = '0;
        editing_next = 1'b0;
        entry_timer_next = load_of(entry_timeout);
      end
      default: ;
    endcase

    for (int i = 0; i < CODE_LEN; i++) begin
      if (entry_digits_next[i] != stored_code[i]) same_stored = 1'b0;
      if ({1'b0, entry_digits_next[i]} != master_dig[i]) same_master = 1'b0;
      if (entry_digits_next[i] != first_entry[i]) same_first = 1'b0;
    end
    res_count = 3'(fin_count);

    if (finish) begin
      if (entry_mode == MODE_FIRST) begin
        first_entry_next = entry_digits_next;
        entry_mode_next = MODE_SECOND;
      end else if (entry_mode == MODE_SECOND) begin
        res_valid = 1'b1;
        if (same_first) begin
          stored_code_next = first_entry;
          res_outcome = OUT_SAVED;
        end else begin
          res_outcome = OUT_REJECTED;
        end
        entry_mode_next = MODE_UNLOCK;
      end else begin
        res_valid = 1'b1;
        res_outcome = same_stored ? OUT_MATCH : (same_master ? OUT_MASTER : OUT_MISMATCH);
        entry_mode_next = MODE_UNLOCK;
      end
      for (int i = 0; i < CODE_LEN; i++) begin
        entry_digits_next[i] = '0;
      end
      write_count_next = '0;
      cursor_next = '0;
      editing_next = 1'b0;
      entry_timer_next = load_of(entry_timeout);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_mode <= MODE_UNLOCK;
      editing <= 1'b0;
      write_count <= '0;
      cursor <= '0;
      entry_timer <= TIMEOUT_RESET;
      edit_timer <= TIMEOUT_RESET;
      for (int i = 0; i < CODE_LEN; i++) begin
        entry_digits[i] <= '0;
        stored_code[i] <= '0;
        first_entry[i] <= '0;
      end
    end else if (accept) begin
      entry_mode <= entry_mode_next;
      editing <= editing_next;
      write_count <= write_count_next;
      cursor <= cursor_next;
      entry_timer <= entry_timer_next;
      edit_timer <= edit_timer_next;
      entry_digits <= entry_digits_next;
      stored_code <= stored_code_next;
      first_entry <= first_entry_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        outcome <= skid_outcome;
        digits_entered <= skid_count;
        skid_valid <= accept && res_valid;
        skid_outcome <= res_outcome;
        skid_count <= res_count;
      end else begin
        out_valid <= accept && res_valid;
        outcome <= res_outcome;
        digits_entered <= res_count;
      end
    end else if (!out_valid) begin
      out_valid <= accept && res_valid;
      outcome <= res_outcome;
      digits_entered <= res_count;
    end else if (accept && res_valid) begin
      skid_valid <= 1'b1;
      skid_outcome <= res_outcome;
      skid_count <= res_count;
    end
  end

  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("Skid slot holds a result while the output slot is empty.");

  assert property (@(posedge clk) disable iff (rst) write_count < CW'(CODE_LEN))
    else $error("Write position reached the code length without finishing.");

  assert property (@(posedge clk) disable iff (rst)
    accept && cmd == CMD_CHANGE |=> entry_mode == MODE_FIRST && write_count == '0 && !editing)
    else $error("Begin change did not start a fresh first entry.");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import kcl_pkg::*;

  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD = 100;
  localparam int DRAIN_CYCLES = 4;
  localparam int PRINT_CAP = 25;

  typedef struct packed {
    logic [2:0] outcome;
    logic [2:0] count;
  } lock_result_t;

  class lock_outcome_tracker;
    reg_t master_code;
    reg_t entry_limit;
    reg_t edit_limit;
    logic [1:0] mode;
    bit editing;
    digit_t entry_dig[CODE_LEN_DEF];
    digit_t stored_dig[CODE_LEN_DEF];
    digit_t first_dig[CODE_LEN_DEF];
    int unsigned write_pos;
    int unsigned cursor;
    int unsigned entry_timer;
    int unsigned edit_timer;
    lock_result_t pending_outcomes[$];
    int unsigned errors;
    int unsigned requests;
    int unsigned results;
    int unsigned outcome_seen[5];

    function new();
      master_code = MASTER_RESET;
      entry_limit = TIMEOUT_RESET;
      edit_limit = TIMEOUT_RESET;
      mode = MODE_UNLOCK;
      stored_dig = '{default: '0};
      first_dig = '{default: '0};
      clear_entry();
      edit_timer = reload(edit_limit);
    endfunction

    function int unsigned reload(reg_t r);
      return (r == '0) ? 1 : int'(r);
    endfunction

    function void set_register(logic [1:0] idx, reg_t value);
      case (idx)
        REG_MASTER: master_code = value;
        REG_ENTRY_TO: entry_limit = value;
        REG_EDIT_TO: edit_limit = value;
        default: ;
      endcase
    endfunction

    function void clear_entry();
      entry_dig = '{default: '0};
      write_pos = 0;
      cursor = 0;
      editing = 1'b0;
      entry_timer = reload(entry_limit);
    endfunction

    function void close_entry();
      bit same_stored = 1'b1;
      bit same_master = 1'b1;
      bit same_first = 1'b1;
      lock_result_t r;
      for (int i = 0; i < CODE_LEN_DEF; i++) begin
        if (entry_dig[i] != stored_dig[i]) same_stored = 1'b0;
        if ({1'b0, entry_dig[i]} != master_code[(3 - i) * NIBBLE_W +: NIBBLE_W])
          same_master = 1'b0;
        if (entry_dig[i] != first_dig[i]) same_first = 1'b0;
      end
      r.count = 3'(write_pos);
      case (mode)
        MODE_FIRST: begin
          first_dig = entry_dig;
          mode = MODE_SECOND;
        end
        MODE_SECOND: begin
          if (same_first) begin
            stored_dig = first_dig;
            r.outcome = OUT_SAVED;
          end else begin
            r.outcome = OUT_REJECTED;
          end
          pending_outcomes.push_back(r);
          mode = MODE_UNLOCK;
        end
        default: begin
          r.outcome = same_stored ? OUT_MATCH : (same_master ? OUT_MASTER : OUT_MISMATCH);
          pending_outcomes.push_back(r);
          mode = MODE_UNLOCK;
        end
      endcase
      clear_entry();
    endfunction

    function void note_request(logic [2:0] c, logic [2:0] k);
      requests++;
      case (c)
        CMD_TICK: begin
          if (editing) begin
            if (edit_timer <= 1) editing = 1'b0;
            else edit_timer--;
          end else if (entry_timer <= 1) begin
            close_entry();
          end else begin
            entry_timer--;
          end
        end
        CMD_DIGIT: begin
          if (k >= KEY_MIN && k <= KEY_MAX) begin
            if (editing) begin
              if (cursor < write_pos) begin
                entry_dig[cursor] = k;
                edit_timer = reload(edit_limit);
              end
            end else begin
              entry_dig[write_pos] = k;
              write_pos++;
              entry_timer = reload(entry_limit);
              if (write_pos >= CODE_LEN_DEF) close_entry();
              else cursor = write_pos;
            end
          end
        end
        CMD_MOVE: begin
          cursor = (cursor + 1) % CODE_LEN_DEF;
          editing = 1'b1;
          edit_timer = reload(edit_limit);
        end
        CMD_CONFIRM: begin
          if (editing) begin
            editing = 1'b0;
            cursor = write_pos % CODE_LEN_DEF;
          end else begin
            close_entry();
          end
        end
        CMD_CHANGE: begin
          mode = MODE_FIRST;
          first_dig = '{default: '0};
          clear_entry();
        end
        default: ;
      endcase
    endfunction

    task flag_mismatch(string what);
      if (errors < PRINT_CAP) $display("error at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [2:0] o, logic [2:0] d);
      lock_result_t want;
      if (pending_outcomes.size() == 0) begin
        flag_mismatch($sformatf("result with none pending: outcome %0d digits %0d", o, d));
        return;
      end
      want = pending_outcomes.pop_front();
      results++;
      if (want.outcome <= OUT_REJECTED) outcome_seen[want.outcome]++;
      if (o !== want.outcome)
        flag_mismatch($sformatf("outcome %0d, wanted %0d", o, want.outcome));
      if (d !== want.count)
        flag_mismatch($sformatf("digits_entered %0d, wanted %0d", d, want.count));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [2:0] cmd;
  logic [2:0] key_digit;
  logic out_valid;
  logic out_stall;
  logic [2:0] outcome;
  logic [2:0] digits_entered;
  logic cfg_we;
  logic [1:0] cfg_index;
  reg_t cfg_data;

  lock_outcome_tracker tracker;
  bit tx_no_idle;
  bit rx_no_idle;
  bit rx_hold_long;
  int idle_cycles;

  keypad_code_lock_entry i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .key_digit(key_digit),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .outcome(outcome),
    .digits_entered(digits_entered),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0)
      tracker.check_result(outcome, digits_entered);
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : result_sink
    int hold;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      hold = rx_no_idle ? 0 : $urandom_range(0, 15);
      if (rx_hold_long) begin
        hold = LONG_HOLD;
        rx_hold_long = 1'b0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  task automatic send(input logic [2:0] c, input logic [2:0] k);
    int gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    key_digit <= k;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.note_request(c, k);
  endtask

  task automatic press(input logic [2:0] c);
    send(c, 3'($urandom_range(0, 7)));
  endtask

  function automatic int lead_len(input digit_t d[CODE_LEN_DEF]);
    int n = 0;
    while (n < CODE_LEN_DEF && d[n] != '0) n++;
    return n;
  endfunction

  function automatic int master_target(output digit_t d[CODE_LEN_DEF]);
    int n = 0;
    bit run = 1'b1;
    logic [NIBBLE_W-1:0] nib;
    for (int i = 0; i < MASTER_DIGITS; i++) begin
      nib = tracker.master_code[(3 - i) * NIBBLE_W +: NIBBLE_W];
      if (run && nib >= KEY_MIN && nib <= KEY_MAX) begin
        d[i] = nib[2:0];
        n++;
      end else begin
        run = 1'b0;
        d[i] = '0;
      end
    end
    return n;
  endfunction

  function automatic reg_t draw_master();
    reg_t m;
    for (int i = 0; i < MASTER_DIGITS; i++)
      m[i * NIBBLE_W +: NIBBLE_W] = ($urandom_range(0, 4) == 0) ?
          4'($urandom_range(0, 15)) : 4'($urandom_range(1, 4));
    return m;
  endfunction

  function automatic int draw_length();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, CODE_LEN_DEF - 1) : CODE_LEN_DEF;
  endfunction

  function automatic void draw_code(output digit_t d[CODE_LEN_DEF], input int n);
    for (int i = 0; i < CODE_LEN_DEF; i++)
      d[i] = (i < n) ? digit_t'($urandom_range(1, 4)) : digit_t'(0);
  endfunction

  // Types one entry of n digits. Now and then a wrong digit goes in and is
  // put right through edit mode, and the entry may end by timing out.
  task automatic play_entry(input digit_t code[CODE_LEN_DEF], input int n);
    int fix_p;
    int fix_w;
    int steps;
    fix_p = -1;
    fix_w = -1;
    while (tracker.editing || tracker.write_pos != 0) press(CMD_CONFIRM);
    if (n > 0 && $urandom_range(0, 2) == 0) begin
      fix_p = $urandom_range(0, (n == CODE_LEN_DEF) ? n - 2 : n - 1);
      fix_w = $urandom_range(fix_p + 1, (n == CODE_LEN_DEF) ? n - 1 : n);
    end
    for (int i = 0; i <= n; i++) begin
      if (i == fix_w) begin
        repeat ((fix_p - fix_w + CODE_LEN_DEF) % CODE_LEN_DEF) press(CMD_MOVE);
        send(CMD_DIGIT, code[fix_p]);
        steps = tracker.edit_timer;
        if (steps <= 40 && $urandom_range(0, 1) == 0) repeat (steps) press(CMD_TICK);
        else press(CMD_CONFIRM);
      end
      if (i == n) break;
      case ($urandom_range(0, 11))
        0: send(CMD_DIGIT, ($urandom_range(0, 3) == 0) ? 3'd0 : 3'($urandom_range(5, 7)));
        1: if (tracker.entry_timer > 2) press(CMD_TICK);
        default: ;
      endcase
      send(CMD_DIGIT, (i == fix_p) ? digit_t'(code[i] % 4 + 1) : code[i]);
    end
    if (n < CODE_LEN_DEF) begin
      steps = tracker.entry_timer;
      if (steps <= 40 && $urandom_range(0, 2) == 0) repeat (steps) press(CMD_TICK);
      else press(CMD_CONFIRM);
    end
  endtask

  task automatic random_episode();
    digit_t code[CODE_LEN_DEF];
    digit_t again[CODE_LEN_DEF];
    int n;
    int i;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      case ($urandom_range(0, 3))
        0: begin
          code = tracker.stored_dig;
          n = lead_len(code);
        end
        1: n = master_target(code);
        default: begin
          n = draw_length();
          draw_code(code, n);
        end
      endcase
      play_entry(code, n);
    end else if (pick < 60) begin
      n = draw_length();
      draw_code(code, n);
      again = code;
      if (n > 0 && $urandom_range(0, 3) == 0) begin
        i = $urandom_range(0, n - 1);
        again[i] = digit_t'(again[i] % 4 + 1);
      end
      press(CMD_CHANGE);
      play_entry(code, n);
      play_entry(again, n);
      if ($urandom_range(0, 1) == 0) play_entry(tracker.stored_dig, lead_len(tracker.stored_dig));
    end else if (pick < 72) begin
      repeat ($urandom_range(3, 12)) begin
        i = $urandom_range(0, 9);
        if (i < 4) send(CMD_DIGIT, 3'($urandom_range(1, 4)));
        else if (i < 7) press(CMD_MOVE);
        else if (i < 9) press(CMD_CONFIRM);
        else press(CMD_TICK);
      end
    end else if (pick < 84) begin
      repeat ($urandom_range(1, 6)) press(CMD_TICK);
    end else begin
      repeat ($urandom_range(1, 6)) send(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input reg_t master, input reg_t entry_to, input reg_t edit_to,
                           input bit tx_fast, input bit rx_fast, input bit squeeze,
                           input int count);
    digit_t code[CODE_LEN_DEF];
    int stop;
    settle();
    cfg_we <= 1'b1;
    cfg_index <= REG_MASTER;
    cfg_data <= master;
    @(posedge clk);
    cfg_index <= REG_ENTRY_TO;
    cfg_data <= entry_to;
    @(posedge clk);
    cfg_index <= REG_EDIT_TO;
    cfg_data <= edit_to;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_register(REG_MASTER, master);
    tracker.set_register(REG_ENTRY_TO, entry_to);
    tracker.set_register(REG_EDIT_TO, edit_to);
    tx_no_idle = tx_fast;
    rx_no_idle = rx_fast;
    // Keep the output blocked while full entries stream in back to back, so
    // the result buffer fills and the input side has to stall.
    if (squeeze) begin
      rx_hold_long = 1'b1;
      tx_no_idle = 1'b1;
      repeat (12) begin
        draw_code(code, CODE_LEN_DEF);
        play_entry(code, CODE_LEN_DEF);
      end
      tx_no_idle = tx_fast;
    end
    stop = tracker.requests + count;
    while (tracker.requests < stop) random_episode();
  endtask

  initial begin
    tracker = new();
    rst <= 1'b1;
    in_valid <= 1'b0;
    cmd <= CMD_TICK;
    key_digit <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_MASTER;
    cfg_data <= '0;
    idle_cycles <= 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // An empty entry against the all-zero stored code, then the reset master code.
    press(CMD_CONFIRM);
    send(CMD_DIGIT, KEY_MIN);
    send(CMD_DIGIT, KEY_MIN);
    send(CMD_DIGIT, KEY_MAX);
    send(CMD_DIGIT, KEY_MAX);
    // Out-of-range keys and an unknown command are dropped.
    send(CMD_DIGIT, 3'd0);
    send(CMD_DIGIT, 3'd7);
    send(CMD_UNUSED_HI, 3'd3);
    // Edit mode: a digit on an empty position is dropped, a filled one is replaced.
    send(CMD_DIGIT, 3'd2);
    press(CMD_MOVE);
    send(CMD_DIGIT, 3'd3);
    press(CMD_MOVE);
    press(CMD_MOVE);
    send(CMD_DIGIT, KEY_MAX);
    press(CMD_CONFIRM);
    // Begin change drops the partial entry; two equal entries save the code.
    press(CMD_CHANGE);
    repeat (2) begin
      send(CMD_DIGIT, 3'd3);
      send(CMD_DIGIT, 3'd2);
      send(CMD_DIGIT, 3'd1);
      send(CMD_DIGIT, 3'd4);
    end

    run_phase(16'h0000, 16'd1, 16'd1, 1'b0, 1'b0, 1'b0, 250);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, 250);
    run_phase(draw_master(), 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 250);
    run_phase(draw_master(), reg_t'($urandom_range(2, 12)), reg_t'($urandom_range(2, 12)),
              1'b1, 1'b1, 1'b1, 250);
    run_phase(draw_master(), reg_t'($urandom_range(1, 30)), reg_t'($urandom_range(1, 30)),
              1'b1, 1'b0, 1'b0, 250);
    run_phase(draw_master(), reg_t'($urandom_range(1, 16)), reg_t'($urandom_range(1, 16)),
              1'b0, 1'b1, 1'b0, 250);
    run_phase(draw_master(), reg_t'($urandom_range(1, 8)), reg_t'($urandom_range(1, 8)),
              1'b0, 1'b0, 1'b0, 250);
    settle();

    if (tracker.pending_outcomes.size() != 0)
      tracker.flag_mismatch($sformatf("%0d results never arrived",
                                      tracker.pending_outcomes.size()));
    $display("Sent %0d keypad requests over seven register settings; %0d results checked.",
             tracker.requests, tracker.results);
    $display("Outcomes: %0d match, %0d master, %0d mismatch, %0d saved, %0d rejected.",
             tracker.outcome_seen[OUT_MATCH], tracker.outcome_seen[OUT_MASTER],
             tracker.outcome_seen[OUT_MISMATCH], tracker.outcome_seen[OUT_SAVED],
             tracker.outcome_seen[OUT_REJECTED]);
    if (tracker.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
